### src/ffsu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the FTRL / factorization-machine update engine.
// Used by the controller, the datapath and the top level; no dependencies.
package ffsu_pkg;

	localparam int NUM_FEATURES = 4096;
	localparam int MAX_FM_DIM   = 16;
	localparam int IDX_W        = $clog2(NUM_FEATURES);
	localparam int SLOT_W       = $clog2(MAX_FM_DIM);
	localparam int FM_DEPTH     = NUM_FEATURES * MAX_FM_DIM;
	localparam int FM_AW        = IDX_W + SLOT_W;
	localparam int DIM_W        = 5;
	localparam int CFG_IDX_W    = 2;

	// square root of a 49-bit operand: one result bit per step
	localparam int SQRT_STEPS = 25;
	// restoring division of a 64-bit dividend: one quotient bit per step
	localparam int DIV_STEPS  = 64;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	// 1.0 in Q16.16
	localparam logic [24:0] ONE_Q = 25'd65536;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_BIAS = 2'd1;
	localparam logic [1:0] OP_FEAT = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_SKIP = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INV_ALPHA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FM_RATE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FM_L2     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FM_DIM    = 2'd3;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_MUL_EE,
		CMD_ESQ,
		CMD_MUL_EV,
		CMD_G,
		CMD_G_BIAS,
		CMD_MUL_GG,
		CMD_G2,
		CMD_RD,
		CMD_SQ_S,
		CMD_SQ_N,
		CMD_SQ_F,
		CMD_SQ_STEP,
		CMD_MUL_DA,
		CMD_T,
		CMD_MUL_TW,
		CMD_LIN_WR,
		CMD_MUL_GR,
		CMD_DIV_LR,
		CMD_DIV_L2,
		CMD_DIV_STEP,
		CMD_REG,
		CMD_W_MUL1,
		CMD_W_W2,
		CMD_W_MUL2,
		CMD_W_WR,
		CMD_FSQ_WR,
		CMD_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t             op;
		logic [FM_AW-1:0]   clr_addr;
		logic [SLOT_W-1:0]  k;
	} dp_cmd_t;

	typedef struct packed {
		logic               e_zero;
		logic [DIM_W-1:0]   walk_n;
	} dp_stat_t;

	typedef enum logic [5:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL_EE,
		S_ESQ,
		S_G_BIAS,
		S_MUL_EV,
		S_G,
		S_MUL_GG,
		S_G2,
		S_RD,
		S_SQ_S,
		S_SQ_S_RUN,
		S_SQ_N,
		S_SQ_N_RUN,
		S_MUL_DA,
		S_T,
		S_MUL_TW,
		S_LIN_WR,
		S_SQ_F,
		S_SQ_F_RUN,
		S_MUL_GR,
		S_DIV_LR,
		S_DIV_LR_RUN,
		S_DIV_L2,
		S_DIV_L2_RUN,
		S_REG,
		S_W_RD,
		S_W_MUL1,
		S_W_W2,
		S_W_MUL2,
		S_W_WR,
		S_FSQ_WR,
		S_DONE
	} ctrl_state_t;

endpackage

### src/ffsu_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/ffsu_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the update engine: clearing pass, per-item step order,
// iteration counts of the root and divide units, factor walk, output handshake.
// Depends on ffsu_pkg.
module ffsu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	output logic              out_valid,
	input  logic              out_ready,
	output ffsu_pkg::dp_cmd_t cmd,
	input  ffsu_pkg::dp_stat_t stat
);
	import ffsu_pkg::*;

	ctrl_state_t       state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [SLOT_W-1:0] k_q, k_d;
	logic [FM_AW-1:0]  clr_q, clr_d;
	logic [1:0]        op_q;
	logic              out_valid_q;
	dp_op_t            cmd_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			k_q         <= '0;
			clr_q       <= '0;
			op_q        <= OP_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
			clr_q   <= clr_d;
			if (in_valid && in_ready) begin
				op_q <= opcode;
			end
			if (cmd_op == CMD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q + CNT_W'(1);
		k_d      = k_q;
		clr_d    = clr_q;
		cmd_op   = CMD_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd_op = CMD_CLEAR;
				clr_d  = clr_q + FM_AW'(1);
				if (&clr_q) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_op  = CMD_LOAD;
					state_d = (opcode == OP_BIAS || opcode == OP_FEAT) ? S_MUL_EE : S_DONE;
				end
			end
			S_MUL_EE: begin
				cmd_op  = CMD_MUL_EE;
				state_d = S_ESQ;
			end
			S_ESQ: begin
				cmd_op  = CMD_ESQ;
				state_d = (op_q == OP_BIAS) ? S_G_BIAS : S_MUL_EV;
			end
			S_G_BIAS: begin
				cmd_op  = CMD_G_BIAS;
				state_d = S_RD;
			end
			S_MUL_EV: begin
				cmd_op  = CMD_MUL_EV;
				state_d = S_G;
			end
			S_G: begin
				cmd_op  = CMD_G;
				state_d = S_MUL_GG;
			end
			S_MUL_GG: begin
				cmd_op  = CMD_MUL_GG;
				state_d = S_G2;
			end
			S_G2: begin
				cmd_op  = CMD_G2;
				state_d = S_RD;
			end
			S_RD: begin
				cmd_op  = CMD_RD;
				state_d = S_SQ_S;
			end
			S_SQ_S: begin
				cmd_op  = CMD_SQ_S;
				cnt_d   = '0;
				state_d = S_SQ_S_RUN;
			end
			S_SQ_S_RUN: begin
				cmd_op = CMD_SQ_STEP;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = S_SQ_N;
			end
			S_SQ_N: begin
				cmd_op  = CMD_SQ_N;
				cnt_d   = '0;
				state_d = S_SQ_N_RUN;
			end
			S_SQ_N_RUN: begin
				cmd_op = CMD_SQ_STEP;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = S_MUL_DA;
			end
			S_MUL_DA: begin
				cmd_op  = CMD_MUL_DA;
				state_d = S_T;
			end
			S_T: begin
				cmd_op  = CMD_T;
				state_d = S_MUL_TW;
			end
			S_MUL_TW: begin
				cmd_op  = CMD_MUL_TW;
				state_d = S_LIN_WR;
			end
			S_LIN_WR: begin
				cmd_op  = CMD_LIN_WR;
				// bias items and zero error stop after the linear part
				state_d = (op_q == OP_BIAS || stat.e_zero) ? S_DONE : S_SQ_F;
			end
			S_SQ_F: begin
				cmd_op  = CMD_SQ_F;
				cnt_d   = '0;
				state_d = S_SQ_F_RUN;
			end
			S_SQ_F_RUN: begin
				cmd_op = CMD_SQ_STEP;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = S_MUL_GR;
			end
			S_MUL_GR: begin
				cmd_op  = CMD_MUL_GR;
				state_d = S_DIV_LR;
			end
			S_DIV_LR: begin
				cmd_op  = CMD_DIV_LR;
				cnt_d   = '0;
				state_d = S_DIV_LR_RUN;
			end
			S_DIV_LR_RUN: begin
				cmd_op = CMD_DIV_STEP;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_DIV_L2;
			end
			S_DIV_L2: begin
				cmd_op  = CMD_DIV_L2;
				cnt_d   = '0;
				state_d = S_DIV_L2_RUN;
			end
			S_DIV_L2_RUN: begin
				cmd_op = CMD_DIV_STEP;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_REG;
			end
			S_REG: begin
				cmd_op  = CMD_REG;
				k_d     = '0;
				state_d = (stat.walk_n == '0) ? S_FSQ_WR : S_W_RD;
			end
			S_W_RD: begin
				state_d = S_W_MUL1;
			end
			S_W_MUL1: begin
				cmd_op  = CMD_W_MUL1;
				state_d = S_W_W2;
			end
			S_W_W2: begin
				cmd_op  = CMD_W_W2;
				state_d = S_W_MUL2;
			end
			S_W_MUL2: begin
				cmd_op  = CMD_W_MUL2;
				state_d = S_W_WR;
			end
			S_W_WR: begin
				cmd_op = CMD_W_WR;
				if ({1'b0, k_q} + DIM_W'(1) == stat.walk_n) begin
					state_d = S_FSQ_WR;
				end else begin
					k_d     = k_q + SLOT_W'(1);
					state_d = S_W_RD;
				end
			end
			S_FSQ_WR: begin
				cmd_op  = CMD_FSQ_WR;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd_op  = CMD_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign cmd.op       = cmd_op;
	assign cmd.clr_addr = clr_q;
	assign cmd.k        = k_q;

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_op == CMD_OUT) |-> (!out_valid_q || out_ready))
		else $error("result loaded over an unread result");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("input accepted during clearing pass");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_W_WR) |-> ({1'b0, k_q} < stat.walk_n))
		else $error("factor walk index beyond walk count");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_L2) |-> !stat.e_zero)
		else $error("division by a zero error value");

endmodule

### src/ffsu_dp.sv
`timescale 1ns / 1ps
// Datapath of the update engine: configuration registers, shared multiplier,
// bit-serial square root and divider, accumulator memories and result register.
// Depends on ffsu_pkg and ffsu_ram.
module ffsu_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffsu_pkg::dp_cmd_t             cmd,
	output ffsu_pkg::dp_stat_t            stat,
	input  logic                          cfg_we,
	input  logic [ffsu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic [1:0]                    opcode,
	input  logic [ffsu_pkg::IDX_W-1:0]    feature_index,
	input  logic signed [31:0]            feature_value,
	input  logic signed [31:0]            pred_error,
	input  logic signed [31:0]            lin_weight,
	input  logic [ffsu_pkg::SLOT_W-1:0]   fm_slot,
	input  logic signed [31:0]            fm_sum,
	input  logic                          last_of_sample,
	output logic signed [31:0]            new_lin_accum,
	output logic [31:0]                   new_lin_sq_sum,
	output logic [1:0]                    status,
	output logic                          sample_done
);
	import ffsu_pkg::*;

	function automatic logic [32:0] sat_s32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
		if (x < -66'sd2147483648) return {1'b1, 32'h8000_0000};
		return {1'b0, x[31:0]};
	endfunction

	function automatic logic [32:0] sat_u32(input logic [65:0] x);
		if (x > 66'd4294967295) return {1'b1, 32'hFFFF_FFFF};
		return {1'b0, x[31:0]};
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] a);
		return a[31] ? (~a + 32'd1) : a;
	endfunction

	function automatic logic signed [65:0] sx66(input logic [31:0] a);
		return $signed({{34{a[31]}}, a});
	endfunction

	// Q16.16 product from the magnitude product, truncated toward zero
	function automatic logic signed [65:0] qprod(input logic [63:0] p, input logic neg);
		logic signed [65:0] m;
		m = $signed({18'd0, p[63:16]});
		return neg ? -m : m;
	endfunction

	// configuration
	logic [31:0]      inv_alpha_q, fm_rate_q, fm_l2_q;
	logic [DIM_W-1:0] fm_dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_alpha_q <= 32'd3276800;
			fm_rate_q   <= 32'd655;
			fm_l2_q     <= 32'd6554;
			fm_dim_q    <= DIM_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INV_ALPHA: inv_alpha_q <= cfg_data;
				CFG_FM_RATE:   fm_rate_q   <= cfg_data;
				CFG_FM_L2:     fm_l2_q     <= cfg_data;
				CFG_FM_DIM:    fm_dim_q    <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// item and working registers
	logic [1:0]       op_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      e_q, v_q, w_q, g_q;
	logic             last_q, flag_q;
	logic [31:0]      esq_q, g2_q, ni_q, zold_q, fmsq_q, t_q, z_q, n_q;
	logic [32:0]      s_q;
	logic [24:0]      rs_q, den_q;
	logic [31:0]      lr_q, reg_q, z0_q, w2_q;
	logic [63:0]      prod_q;
	logic [48:0]      sq_x_q, sq_r_q, sq_b_q;
	logic [31:0]      rem_q, dsr_q;
	logic [63:0]      dq_q;
	logic [31:0]      buf_q [MAX_FM_DIM];

	// memory ports
	logic [31:0]      lin_acc_rd, lin_sq_rd, fmsq_rd, fm_rd;
	logic [IDX_W-1:0] lin_addr;
	logic [FM_AW-1:0] fm_addr;
	logic             clr, lin_we, fsq_we, fm_we;

	// combinational results
	logic [31:0] mul_a, mul_b;
	logic        mul_en;
	logic [63:0] mul_p;
	logic [32:0] pu_c, g_c, z_c, n_c, lr_c, reg_c, w2_c, r_c, fsq_c;
	logic [32:0] s_c;
	logic [24:0] d_c;
	logic [49:0] sq_sum;
	logic        sq_ge;
	logic [32:0] dv_trial;
	logic        dv_ge;
	logic signed [65:0] qm_c;
	logic [31:0] bw;

	assign bw = buf_q[cmd.k];

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (cmd.op)
			CMD_MUL_EE: begin
				mul_a = mag32(e_q);
				mul_b = mag32(e_q);
			end
			CMD_MUL_EV: begin
				mul_a = mag32(e_q);
				mul_b = mag32(v_q);
			end
			CMD_MUL_GG: begin
				mul_a = mag32(g_q);
				mul_b = mag32(g_q);
			end
			CMD_MUL_DA: begin
				mul_a = {7'd0, d_c};
				mul_b = inv_alpha_q;
			end
			CMD_MUL_TW: begin
				mul_a = t_q;
				mul_b = mag32(w_q);
			end
			CMD_MUL_GR: begin
				mul_a = mag32(g_q);
				mul_b = fm_rate_q;
			end
			CMD_W_MUL1: begin
				mul_a = mag32(fm_rd);
				mul_b = mag32(reg_q);
			end
			CMD_W_MUL2: begin
				mul_a = mag32(lr_q);
				mul_b = mag32(w2_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		d_c    = rs_q - sq_r_q[24:0];
		pu_c   = sat_u32({18'd0, prod_q[63:16]});
		g_c    = sat_s32(qprod(prod_q, e_q[31] ^ v_q[31]));
		z_c    = sat_s32(sx66(zold_q) + sx66(g_q) - qprod(prod_q, w_q[31]));
		n_c    = sat_u32({33'd0, s_q});
		s_c    = {1'b0, ni_q} + {1'b0, g2_q};
		qm_c   = $signed({2'b00, dq_q});
		lr_c   = sat_s32(g_q[31] ? -qm_c : qm_c);
		reg_c  = sat_s32(sx66(v_q) - (e_q[31] ? -qm_c : qm_c));
		w2_c   = sat_s32(sx66(bw) - qprod(prod_q, z0_q[31] ^ reg_q[31]));
		r_c    = sat_s32(sx66(z0_q) - qprod(prod_q, lr_q[31] ^ w2_q[31]));
		fsq_c  = sat_u32({34'd0, fmsq_q} + {34'd0, esq_q});
		sq_sum = {1'b0, sq_r_q} + {1'b0, sq_b_q};
		sq_ge  = {1'b0, sq_x_q} >= sq_sum;
		dv_trial = {rem_q, dq_q[63]};
		dv_ge    = dv_trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_p;
		end
		case (cmd.op)
			CMD_LOAD: begin
				op_q   <= opcode;
				idx_q  <= (opcode == OP_BIAS) ? '0 : feature_index;
				e_q    <= pred_error;
				v_q    <= feature_value;
				w_q    <= lin_weight;
				last_q <= last_of_sample;
				flag_q <= 1'b0;
				if (opcode == OP_LOAD) buf_q[fm_slot] <= fm_sum;
			end
			CMD_ESQ: begin
				esq_q  <= pu_c[31:0];
				flag_q <= flag_q | pu_c[32];
			end
			CMD_G: begin
				g_q    <= g_c[31:0];
				flag_q <= flag_q | g_c[32];
			end
			CMD_G_BIAS: begin
				g_q  <= e_q;
				g2_q <= esq_q;
			end
			CMD_G2: begin
				g2_q   <= pu_c[31:0];
				flag_q <= flag_q | pu_c[32];
			end
			CMD_RD: begin
				ni_q   <= lin_sq_rd;
				zold_q <= lin_acc_rd;
				fmsq_q <= fmsq_rd;
			end
			CMD_SQ_S: begin
				s_q    <= s_c;
				sq_x_q <= {s_c, 16'd0};
				sq_r_q <= '0;
				sq_b_q <= 49'd1 << 48;
			end
			CMD_SQ_N: begin
				rs_q   <= sq_r_q[24:0];
				sq_x_q <= {1'b0, ni_q, 16'd0};
				sq_r_q <= '0;
				sq_b_q <= 49'd1 << 48;
			end
			CMD_SQ_F: begin
				sq_x_q <= {1'b0, fmsq_q, 16'd0};
				sq_r_q <= '0;
				sq_b_q <= 49'd1 << 48;
			end
			CMD_SQ_STEP: begin
				if (sq_ge) begin
					sq_x_q <= sq_x_q - sq_sum[48:0];
					sq_r_q <= (sq_r_q >> 1) + sq_b_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_b_q <= sq_b_q >> 2;
			end
			CMD_T: begin
				t_q    <= pu_c[31:0];
				flag_q <= flag_q | pu_c[32];
			end
			CMD_LIN_WR: begin
				z_q    <= z_c[31:0];
				n_q    <= n_c[31:0];
				flag_q <= flag_q | z_c[32] | n_c[32];
			end
			CMD_MUL_GR: begin
				den_q <= {1'b0, sq_r_q[23:0]} + ONE_Q;
			end
			CMD_DIV_LR: begin
				dq_q  <= prod_q;
				rem_q <= '0;
				dsr_q <= {7'd0, den_q};
			end
			CMD_DIV_L2: begin
				lr_q   <= lr_c[31:0];
				flag_q <= flag_q | lr_c[32];
				dq_q   <= {16'd0, fm_l2_q, 16'd0};
				rem_q  <= '0;
				dsr_q  <= mag32(e_q);
			end
			CMD_DIV_STEP: begin
				rem_q <= dv_ge ? 32'(dv_trial - {1'b0, dsr_q}) : dv_trial[31:0];
				dq_q  <= {dq_q[62:0], dv_ge};
			end
			CMD_REG: begin
				reg_q  <= reg_c[31:0];
				flag_q <= flag_q | reg_c[32];
			end
			CMD_W_MUL1: begin
				z0_q <= fm_rd;
			end
			CMD_W_W2: begin
				w2_q   <= w2_c[31:0];
				flag_q <= flag_q | w2_c[32];
			end
			CMD_W_WR: begin
				flag_q <= flag_q | r_c[32];
			end
			CMD_FSQ_WR: begin
				flag_q <= flag_q | fsq_c[32];
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_OUT) begin
			if (op_q == OP_BIAS || op_q == OP_FEAT) begin
				new_lin_accum  <= z_q;
				new_lin_sq_sum <= n_q;
			end else begin
				new_lin_accum  <= '0;
				new_lin_sq_sum <= '0;
			end
			if (flag_q) begin
				status <= STAT_SAT;
			end else if (op_q == OP_FEAT && e_q == '0) begin
				status <= STAT_SKIP;
			end else begin
				status <= STAT_OK;
			end
			sample_done <= last_q;
		end
	end

	assign clr      = (cmd.op == CMD_CLEAR);
	assign lin_addr = clr ? cmd.clr_addr[IDX_W-1:0] : idx_q;
	assign fm_addr  = clr ? cmd.clr_addr : {idx_q, cmd.k};
	assign lin_we   = clr || (cmd.op == CMD_LIN_WR);
	assign fsq_we   = clr || (cmd.op == CMD_FSQ_WR);
	assign fm_we    = clr || (cmd.op == CMD_W_WR);

	ffsu_ram #(.WIDTH(32), .DEPTH(NUM_FEATURES)) u_lin_acc (
		.clk   (clk),
		.we    (lin_we),
		.waddr (lin_addr),
		.wdata (clr ? 32'd0 : z_c[31:0]),
		.raddr (lin_addr),
		.rdata (lin_acc_rd)
	);

	ffsu_ram #(.WIDTH(32), .DEPTH(NUM_FEATURES)) u_lin_sq (
		.clk   (clk),
		.we    (lin_we),
		.waddr (lin_addr),
		.wdata (clr ? 32'd0 : n_c[31:0]),
		.raddr (lin_addr),
		.rdata (lin_sq_rd)
	);

	ffsu_ram #(.WIDTH(32), .DEPTH(NUM_FEATURES)) u_fm_sq (
		.clk   (clk),
		.we    (fsq_we),
		.waddr (lin_addr),
		.wdata (clr ? 32'd0 : fsq_c[31:0]),
		.raddr (lin_addr),
		.rdata (fmsq_rd)
	);

	ffsu_ram #(.WIDTH(32), .DEPTH(FM_DEPTH)) u_fm_acc (
		.clk   (clk),
		.we    (fm_we),
		.waddr (fm_addr),
		.wdata (clr ? 32'd0 : r_c[31:0]),
		.raddr (fm_addr),
		.rdata (fm_rd)
	);

	assign stat.e_zero = (e_q == '0);
	assign stat.walk_n = (fm_dim_q > DIM_W'(MAX_FM_DIM)) ? DIM_W'(MAX_FM_DIM) : fm_dim_q;

endmodule

### src/ftrl_fm_sparse_update_core.sv
`timescale 1ns / 1ps
// FTRL-proximal update engine with factorization-machine factors, Q16.16.
// Channels: input items (in_valid/in_ready), results (out_valid/out_ready),
// configuration writes (cfg_valid/cfg_ready, always ready, index 0..3 for
// inv_alpha, fm_rate, fm_l2, fm_dim). Every input item gives one result.
// Items are handled one at a time by a sequencer over one shared 32x32
// multiplier, a one-bit-per-cycle square root (25 steps) and a one-bit-per-
// cycle divider (64 steps). A new item is taken once the previous one has
// moved into the result register; a stalled receiver holds the result and
// blocks only the next item's completion, not its acceptance.
// After reset the accumulator memories are cleared, one factor row entry per
// cycle, with in_ready low throughout. Configuration writes are taken then
// too; write them only while no item is in flight.
// Depends on ffsu_pkg, ffsu_ctrl, ffsu_dp, ffsu_ram.
module ftrl_fm_sparse_update_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      opcode,
	input  logic [ffsu_pkg::IDX_W-1:0]      feature_index,
	input  logic signed [31:0]              feature_value,
	input  logic signed [31:0]              pred_error,
	input  logic signed [31:0]              lin_weight,
	input  logic [ffsu_pkg::SLOT_W-1:0]     fm_slot,
	input  logic signed [31:0]              fm_sum,
	input  logic                            last_of_sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [31:0]              new_lin_accum,
	output logic [31:0]                     new_lin_sq_sum,
	output logic [1:0]                      status,
	output logic                            sample_done,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ffsu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);
	import ffsu_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	ffsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	ffsu_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.feature_index  (feature_index),
		.feature_value  (feature_value),
		.pred_error     (pred_error),
		.lin_weight     (lin_weight),
		.fm_slot        (fm_slot),
		.fm_sum         (fm_sum),
		.last_of_sample (last_of_sample),
		.new_lin_accum  (new_lin_accum),
		.new_lin_sq_sum (new_lin_sq_sum),
		.status         (status),
		.sample_done    (sample_done)
	);

endmodule

### bench/ftrl_fm_sparse_update_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ftrl_fm_sparse_update_core: a directed table, then random
// well-formed samples under several register settings, checked against an in-bench
// Q16.16 FTRL / factor update model. Depends on ffsu_pkg and the core RTL only.
module ftrl_fm_sparse_update_core_tb;
	import ffsu_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 340;
	localparam longint unsigned U32MAX = 64'hFFFF_FFFF;

	typedef struct {
		logic [1:0]        op;
		logic [IDX_W-1:0]  idx;
		logic [31:0]       v;
		logic [31:0]       e;
		logic [31:0]       w;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       sum;
		logic              last;
		bit                typed;
		logic [31:0]       x_z;
		logic [31:0]       x_n;
		logic [1:0]        x_st;
	} stim_t;

	typedef struct {
		logic [31:0] z;
		logic [31:0] n;
		logic [1:0]  st;
		logic        done;
	} update_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = '0;
	logic [IDX_W-1:0] feature_index = '0;
	logic signed [31:0] feature_value = '0;
	logic signed [31:0] pred_error = '0;
	logic signed [31:0] lin_weight = '0;
	logic [SLOT_W-1:0] fm_slot = '0;
	logic signed [31:0] fm_sum = '0;
	logic last_of_sample = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] new_lin_accum;
	logic [31:0] new_lin_sq_sum;
	logic [1:0] status;
	logic sample_done;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	ftrl_fm_sparse_update_core uut (.*);

	always #6 clk = ~clk;

	// model state
	logic signed [31:0] lin_z [NUM_FEATURES];
	logic [31:0] lin_n [NUM_FEATURES];
	logic signed [31:0] fm_w [FM_DEPTH];
	logic [31:0] fm_n [NUM_FEATURES];
	logic signed [31:0] sum_buf [MAX_FM_DIM];
	logic [MAX_FM_DIM-1:0] buf_loaded = '0;
	logic [31:0] r_inv_alpha = 32'd3276800;
	logic [31:0] r_fm_rate = 32'd655;
	logic [31:0] r_fm_l2 = 32'd6554;
	logic [4:0] r_fm_dim = 5'd8;
	bit clip;

	update_t pending_updates[$];
	int errors = 0;
	int n_items = 0, n_results = 0, n_sat = 0, n_skip = 0, n_phases = 0;
	int stall_cnt = 0;
	bit calm = 0;

	function automatic longint unsigned mag(input longint a);
		return a < 0 ? longint'(0) - a : a;
	endfunction

	function automatic longint mul_q(input longint a, input longint b);
		longint unsigned m;
		m = (mag(a) * mag(b)) >> 16;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clip_s32(input longint x);
		if (x > 64'sd2147483647) begin
			clip = 1;
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			clip = 1;
			return -64'sd2147483648;
		end
		return x;
	endfunction

	function automatic longint unsigned clip_u32(input longint unsigned x);
		if (x > U32MAX) begin
			clip = 1;
			return U32MAX;
		end
		return x;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void linear_ftrl(input int i, input longint g,
			input longint unsigned g2, input longint w);
		longint unsigned ni, s, d, t;
		longint zi, p;
		ni = lin_n[i];
		s = ni + g2;
		d = root_floor(s << 16) - root_floor(ni << 16);
		t = clip_u32((d * r_inv_alpha) >> 16);
		p = mul_q(longint'(t), w);
		zi = lin_z[i];
		lin_z[i] = 32'(clip_s32(zi + g - p));
		lin_n[i] = 32'(clip_u32(s));
	endfunction

	// FTRL / factor update of one item; returns the result it should produce
	function automatic update_t ftrl_step(input stim_t it);
		update_t u;
		longint v, e, w, g, lr, l2e, rg, z0, bw, w2;
		longint unsigned esq, g2, den, lm, qm;
		int i, a, walk;
		bit upd, skip;
		v = signed'(it.v);
		e = signed'(it.e);
		w = signed'(it.w);
		i = it.idx;
		clip = 0;
		upd = 0;
		skip = 0;
		case (it.op)
			OP_LOAD: begin
				sum_buf[it.slot] = it.sum;
				buf_loaded[it.slot] = 1'b1;
			end
			OP_BIAS: begin
				esq = clip_u32((mag(e) * mag(e)) >> 16);
				linear_ftrl(0, e, esq, w);
				i = 0;
				upd = 1;
			end
			OP_FEAT: begin
				esq = clip_u32((mag(e) * mag(e)) >> 16);
				g = clip_s32(mul_q(e, v));
				g2 = clip_u32((mag(g) * mag(g)) >> 16);
				linear_ftrl(i, g, g2, w);
				upd = 1;
				if (e == 0) begin
					skip = 1;
				end else begin
					den = root_floor(longint'(fm_n[i]) << 16) + 65536;
					lm = (mag(g) * r_fm_rate) / den;
					lr = clip_s32(g < 0 ? -longint'(lm) : longint'(lm));
					qm = (longint'(r_fm_l2) << 16) / mag(e);
					l2e = e < 0 ? -longint'(qm) : longint'(qm);
					rg = clip_s32(v - l2e);
					walk = r_fm_dim < MAX_FM_DIM ? r_fm_dim : MAX_FM_DIM;
					for (int k = 0; k < walk; k++) begin
						a = i * MAX_FM_DIM + k;
						z0 = fm_w[a];
						bw = sum_buf[k];
						w2 = clip_s32(bw - mul_q(z0, rg));
						fm_w[a] = 32'(clip_s32(z0 - mul_q(lr, w2)));
					end
					fm_n[i] = 32'(clip_u32(longint'(fm_n[i]) + esq));
				end
			end
			default: ;
		endcase
		u.z = upd ? lin_z[i] : '0;
		u.n = upd ? lin_n[i] : '0;
		u.st = clip ? STAT_SAT : (skip ? STAT_SKIP : STAT_OK);
		u.done = it.last;
		return u;
	endfunction

	// result side: random stall bursts, none in the calm part
	int stall_left = 0;
	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// sample at the falling edge: values stay put up to the accepting edge
	always @(negedge clk) begin
		update_t x;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pending_updates.size() == 0) begin
				$error("result with no pending update: z=%h n=%h st=%0d",
					new_lin_accum, new_lin_sq_sum, status);
				errors++;
			end else begin
				x = pending_updates.pop_front();
				if (new_lin_accum !== x.z) begin
					$error("new_lin_accum: expected %h, got %h", x.z, new_lin_accum);
					errors++;
				end
				if (new_lin_sq_sum !== x.n) begin
					$error("new_lin_sq_sum: expected %h, got %h", x.n, new_lin_sq_sum);
					errors++;
				end
				if (status !== x.st) begin
					$error("status: expected %0d, got %0d", x.st, status);
					errors++;
				end
				if (sample_done !== x.done) begin
					$error("sample_done: expected %0d, got %0d", x.done, sample_done);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// called at a rising edge; returns at the accepting rising edge
	task automatic push_item(input stim_t it);
		update_t u;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		opcode <= it.op;
		feature_index <= it.idx;
		feature_value <= it.v;
		pred_error <= it.e;
		lin_weight <= it.w;
		fm_slot <= it.slot;
		fm_sum <= it.sum;
		last_of_sample <= it.last;
		in_valid <= 1'b1;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		u = ftrl_step(it);
		if (it.typed) begin
			u.z = it.x_z;
			u.n = it.x_n;
			u.st = it.x_st;
		end
		pending_updates.push_back(u);
		n_items++;
		if (u.st == STAT_SAT) n_sat++;
		if (u.st == STAT_SKIP) n_skip++;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_updates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all four registers back to back while idle
	task automatic write_regs(input logic [31:0] ia, input logic [31:0] rt,
			input logic [31:0] l2, input logic [31:0] dm);
		logic [31:0] vals [4];
		vals = '{ia, rt, l2, dm};
		for (int r = 0; r < 4; r++) begin
			cfg_index <= CFG_IDX_W'(r);
			cfg_data <= vals[r];
			cfg_valid <= 1'b1;
			@(negedge clk);
			while (!cfg_ready)
				@(negedge clk);
			case (CFG_IDX_W'(r))
				CFG_INV_ALPHA: r_inv_alpha = vals[r];
				CFG_FM_RATE: r_fm_rate = vals[r];
				CFG_FM_L2: r_fm_l2 = vals[r];
				CFG_FM_DIM: r_fm_dim = vals[r][4:0];
				default: ;
			endcase
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		n_phases++;
	endtask

	function automatic logic [31:0] pick_q(input bit allow_zero);
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return allow_zero ? 32'h0 : 32'h1;
			3, 4: return $urandom;
			default: return 32'($urandom_range(0, 1 << 19)) - (1 << 18);
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		if ($urandom_range(0, 9) < 7)
			return IDX_W'($urandom_range(0, 15));
		return IDX_W'($urandom_range(0, NUM_FEATURES - 1));
	endfunction

	function automatic stim_t blank_item(input logic [1:0] op);
		stim_t it;
		it.op = op;
		it.idx = '0;
		it.v = '0;
		it.e = '0;
		it.w = '0;
		it.slot = '0;
		it.sum = '0;
		it.last = 1'b0;
		it.typed = 0;
		it.x_z = '0;
		it.x_n = '0;
		it.x_st = STAT_OK;
		return it;
	endfunction

	function automatic stim_t rand_feature();
		stim_t it;
		it = blank_item(OP_FEAT);
		it.idx = pick_index();
		it.v = pick_q(1);
		it.e = ($urandom_range(0, 9) == 0) ? 32'h0 : pick_q(0);
		it.w = pick_q(1);
		it.slot = SLOT_W'($urandom);
		it.sum = $urandom;
		return it;
	endfunction

	// one sample: factor-sum loads, a few features, bias update last
	task automatic run_sample();
		stim_t it;
		int walk;
		walk = r_fm_dim < MAX_FM_DIM ? r_fm_dim : MAX_FM_DIM;
		for (int k = 0; k < walk; k++) begin
			it = blank_item(OP_LOAD);
			it.slot = SLOT_W'(k);
			it.sum = pick_q(1);
			it.idx = IDX_W'($urandom);
			it.v = $urandom;
			push_item(it);
		end
		repeat ($urandom_range(1, 6))
			push_item(rand_feature());
		it = blank_item(OP_BIAS);
		it.e = pick_q(1);
		it.w = pick_q(1);
		it.v = $urandom;
		it.last = 1'b1;
		push_item(it);
	endtask

	// noise: unused opcode, stray loads and bias updates, out-of-order features
	task automatic run_noise();
		stim_t it;
		it = rand_feature();
		case ($urandom_range(0, 3))
			0: it.op = OP_NONE;
			1: it.op = OP_LOAD;
			2: it.op = OP_BIAS;
			default: ;
		endcase
		it.last = 1'($urandom);
		// keep unloaded buffer entries out of the factor walk
		if (it.op == OP_FEAT && (buf_loaded != '1))
			it.e = '0;
		push_item(it);
	endtask

	stim_t dir_rows [$];

	initial begin
		stim_t it;
		int budget;
		for (int i = 0; i < NUM_FEATURES; i++) begin
			lin_z[i] = '0;
			lin_n[i] = '0;
			fm_n[i] = '0;
		end
		for (int i = 0; i < FM_DEPTH; i++)
			fm_w[i] = '0;
		for (int i = 0; i < MAX_FM_DIM; i++)
			sum_buf[i] = '0;

		// directed table; loads cover the default walk before any factor update
		for (int k = 0; k < 8; k++) begin
			it = blank_item(OP_LOAD);
			it.slot = SLOT_W'(k);
			it.sum = (k == 0) ? 32'h8000_0000 : (k == 1) ? 32'h7FFF_FFFF : 32'(k << 14);
			it.typed = 1;
			dir_rows.push_back(it);
		end
		it = blank_item(OP_LOAD);
		it.slot = 4'd15;
		it.sum = 32'hFFFF_FFFF;
		it.last = 1'b1;
		it.typed = 1;
		dir_rows.push_back(it);
		it = blank_item(OP_NONE);
		it.idx = '1;
		it.v = 32'h7FFF_FFFF;
		it.e = 32'h7FFF_FFFF;
		it.last = 1'b1;
		it.typed = 1;
		dir_rows.push_back(it);
		// zero-error bias and features on cleared entries give all zero accumulators
		it = blank_item(OP_BIAS);
		it.typed = 1;
		dir_rows.push_back(it);
		it = blank_item(OP_FEAT);
		it.idx = '1;
		it.v = 32'h7FFF_FFFF;
		it.typed = 1;
		it.x_st = STAT_SKIP;
		dir_rows.push_back(it);
		it = blank_item(OP_FEAT);
		it.v = 32'h8000_0000;
		it.w = 32'h7FFF_FFFF;
		it.typed = 1;
		it.x_st = STAT_SKIP;
		dir_rows.push_back(it);
		it = blank_item(OP_BIAS);
		it.e = 32'h8000_0000;
		it.w = 32'h7FFF_FFFF;
		dir_rows.push_back(it);
		it = blank_item(OP_FEAT);
		it.idx = 12'd5;
		it.v = 32'h0001_0000;
		it.e = 32'h0001_0000;
		it.w = 32'h0000_8000;
		dir_rows.push_back(it);
		it.e = 32'hFFFF_0000;
		it.last = 1'b1;
		dir_rows.push_back(it);
		it = blank_item(OP_FEAT);
		it.idx = '1;
		it.v = 32'h7FFF_FFFF;
		it.e = 32'h7FFF_FFFF;
		it.w = 32'h8000_0000;
		dir_rows.push_back(it);
		it = blank_item(OP_FEAT);
		it.idx = 12'd1;
		it.v = 32'h8000_0000;
		it.e = 32'hFFFF_FFFF;
		it.w = 32'hFFFF_FFFF;
		dir_rows.push_back(it);
		it = blank_item(OP_FEAT);
		it.idx = 12'd2;
		it.v = 32'h0000_0001;
		it.e = 32'h8000_0000;
		it.w = 32'h0001_0000;
		dir_rows.push_back(it);
		it = blank_item(OP_BIAS);
		it.e = 32'h0000_4000;
		it.w = 32'h8000_0000;
		it.last = 1'b1;
		dir_rows.push_back(it);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			push_item(dir_rows[r]);

		// random phases; the sender holds off until idle before every register change
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: write_regs(32'd3276800, 32'd655, 32'd6554, 32'd8);
				1: write_regs(32'h0, 32'hFFFF_FFFF, 32'h0, 32'd16);
				2: write_regs(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'd1);
				3: write_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd0);
				4: write_regs($urandom, $urandom, $urandom, 32'd31);
				default: write_regs($urandom_range(0, 1 << 23), $urandom_range(0, 1 << 18),
					$urandom, $urandom_range(1, 16));
			endcase
			calm = (ph == 7);
			budget = n_items + 200;
			while (n_items < budget) begin
				if ($urandom_range(0, 9) < 8)
					run_sample();
				else
					run_noise();
			end
		end

		drain();
		$display("%0d items in, %0d results checked, %0d register settings",
			n_items, n_results, n_phases);
		$display("%0d saturating updates, %0d zero-error factor skips", n_sat, n_skip);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
